### src/sacs_pkg.sv
// ----------------------------------------------------------------------------
// sacs_pkg: shared types and constants for the suffix-automaton matcher
// Item types, kind codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none
package sacs_pkg;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QBEGIN = 2'd2;
    localparam logic [1:0] KIND_QUERY  = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic [14:0] match_length;
        logic [14:0] best_length;
        logic [15:0] states_used;
        logic        status;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR,
        ST_AP_LEN,
        ST_AP_ZERO,
        ST_AP_WALK,
        ST_AP_WALKR,
        ST_AP_Q,
        ST_AP_QR,
        ST_AP_CPYR,
        ST_AP_CPYW,
        ST_AP_LNK,
        ST_AP_RED,
        ST_AP_REDR,
        ST_QY_RD,
        ST_QY_RDR,
        ST_QY_LEN,
        ST_QY_LENR,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

### src/sacs_ram.sv
// ----------------------------------------------------------------------------
// sacs_ram: generic single-port RAM
// One access per cycle: an optional write plus a read of the old word at that address, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module sacs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

### src/suffix_automaton_common_substring.sv
// ----------------------------------------------------------------------------
// suffix_automaton_common_substring: suffix automaton with LCS query
// Builds an automaton over appended symbols and matches a query stream.
// ----------------------------------------------------------------------------
// One item at a time. An append zeroes the new row entry by entry and then
// walks the suffix links, and a split also copies the row of q into the clone
// entry by entry and then redirects transitions; all work goes through one port
// of the transition memory. A query reads the transition and, on a hit, the
// length of its target, with one fallback step through the suffix link per miss.
// Clear sweeps the rows of the used states entry by entry. After reset the root
// row is swept the same way (input stalled); later rows are zeroed when allocated,
// so rows that were never allocated are never read. Each result is held in an
// output register.
`default_nettype none
module suffix_automaton_common_substring #(
    parameter int MAX_TEXT = 16384,
    parameter int ALPHABET = 26
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  sacs_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  wire                 i_stall,
    output sacs_pkg::t_out_item o_item
);
    import sacs_pkg::*;

    localparam int NS  = 2 * MAX_TEXT;
    localparam int SW  = $clog2(NS);
    localparam int AW  = $clog2(ALPHABET);
    localparam int TD  = NS * ALPHABET;
    localparam int TW  = $clog2(TD);
    localparam int LW  = $clog2(MAX_TEXT + 1);
    localparam int CW  = SW + 1;

    // memories
    logic          t_we;
    logic [TW-1:0] t_addr;
    logic [SW-1:0] t_wd, t_rd;
    logic          l_we;
    logic [SW-1:0] l_addr;
    logic [LW-1:0] l_wd, l_rd;
    logic          k_we;
    logic [SW-1:0] k_addr;
    logic [SW:0]   k_wd, k_rd;   // MSB set = no link

    sacs_ram #(.WIDTH(SW), .DEPTH(TD)) u_trans (
        .i_clk(i_clk), .i_we(t_we), .i_addr(t_addr), .i_wdata(t_wd), .o_rdata(t_rd));
    sacs_ram #(.WIDTH(LW), .DEPTH(NS)) u_len (
        .i_clk(i_clk), .i_we(l_we), .i_addr(l_addr), .i_wdata(l_wd), .o_rdata(l_rd));
    sacs_ram #(.WIDTH(SW + 1), .DEPTH(NS)) u_link (
        .i_clk(i_clk), .i_we(k_we), .i_addr(k_addr), .i_wdata(k_wd), .o_rdata(k_rd));

    t_state        r_st, n_st;
    logic [SW-1:0] r_last, n_last;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_ms, n_ms;
    logic [LW-1:0] r_ml, n_ml, r_bl, n_bl;
    logic [LW-1:0] r_lastlen, n_lastlen;
    logic [SW:0]   r_p, n_p;
    logic [SW-1:0] r_cur, n_cur, r_q, n_q, r_cl, n_cl;
    logic [LW-1:0] r_plen, n_plen;
    logic [AW-1:0] r_c, n_c, r_j, n_j;
    logic [SW-1:0] r_row, n_row;
    logic          sym_ok;
    logic          r_stat, n_stat;
    logic          r_ov, n_ov;
    logic          r_boot, n_boot;
    t_out_item     r_out, n_out;

    function automatic logic [TW-1:0] taddr(input logic [SW-1:0] s, input logic [AW-1:0] a);
        logic [TW+SW-1:0] m;
        m = TW'(s) * TW'(ALPHABET) + TW'(a);
        return m[TW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLR;
            r_last <= '0;
            r_cnt <= CW'(1);
            r_ms <= '0;
            r_ml <= '0;
            r_bl <= '0;
            r_lastlen <= '0;
            r_ov <= 1'b0;
            r_row <= '0;
            r_j <= '0;
            r_boot <= 1'b1;
        end else begin
            r_st <= n_st;
            r_last <= n_last;
            r_cnt <= n_cnt;
            r_ms <= n_ms;
            r_ml <= n_ml;
            r_bl <= n_bl;
            r_lastlen <= n_lastlen;
            r_ov <= n_ov;
            r_row <= n_row;
            r_j <= n_j;
            r_boot <= n_boot;
        end
        r_p <= n_p; r_cur <= n_cur; r_q <= n_q; r_cl <= n_cl; r_plen <= n_plen;
        r_c <= n_c;
        r_stat <= n_stat; r_out <= n_out;
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;
    assign o_stall = (r_st != ST_IDLE);

    always_comb begin
        n_st = r_st; n_last = r_last; n_cnt = r_cnt; n_ms = r_ms; n_ml = r_ml;
        n_bl = r_bl; n_lastlen = r_lastlen; n_p = r_p; n_cur = r_cur; n_q = r_q;
        n_cl = r_cl; n_plen = r_plen; n_c = r_c; n_j = r_j; n_row = r_row;
        n_stat = r_stat; n_out = r_out; n_boot = r_boot;
        sym_ok = 1'b0;
        n_ov = r_ov && i_stall;
        t_we = 1'b0; t_addr = '0; t_wd = '0;
        l_we = 1'b0; l_addr = '0; l_wd = '0;
        k_we = 1'b0; k_addr = '0; k_wd = '0;
        unique case (r_st)
            ST_IDLE: begin
                if (i_valid) begin
                    n_c = AW'(i_item.symbol);
                    sym_ok = ({27'd0, i_item.symbol} < 32'(ALPHABET));
                    n_stat = 1'b0;
                    unique case (i_item.kind)
                        KIND_CLEAR: begin
                            n_row = '0; n_j = '0; n_st = ST_CLR;
                        end
                        KIND_APPEND: begin
                            if (32'(r_lastlen) >= 32'(MAX_TEXT)) begin
                                n_stat = 1'b1; n_st = ST_OUT;
                            end else if (sym_ok) begin
                                n_cur = r_cnt[SW-1:0];
                                n_p = {1'b0, r_last};
                                n_plen = r_lastlen;
                                n_j = '0;
                                n_st = ST_AP_LEN;
                            end else begin
                                n_st = ST_OUT;
                            end
                        end
                        KIND_QBEGIN: begin
                            n_ms = '0; n_ml = '0; n_bl = '0; n_st = ST_OUT;
                        end
                        default: begin
                            if (!sym_ok) begin
                                n_ms = '0; n_ml = '0; n_st = ST_OUT;
                            end else begin
                                n_st = ST_QY_RD;
                            end
                        end
                    endcase
                end
            end
            ST_CLR: begin
                t_we = 1'b1; t_addr = taddr(r_row, r_j);
                if (32'(r_j) == ALPHABET - 1) begin
                    n_j = '0;
                    if ({1'b0, r_row} + CW'(1) >= r_cnt) begin
                        l_we = 1'b1; l_addr = '0; l_wd = '0;
                        k_we = 1'b1; k_addr = '0; k_wd = {1'b1, {SW{1'b0}}};
                        n_cnt = CW'(1); n_last = '0; n_lastlen = '0;
                        n_ms = '0; n_ml = '0; n_bl = '0;
                        n_row = '0;
                        // the sweep after reset posts no result
                        n_boot = 1'b0;
                        n_st = r_boot ? ST_IDLE : ST_OUT;
                    end else begin
                        n_row = r_row + SW'(1);
                    end
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            ST_AP_LEN: begin
                l_we = 1'b1; l_addr = r_cur; l_wd = r_plen + LW'(1);
                n_cnt = r_cnt + CW'(1);
                n_st = ST_AP_ZERO;
            end
            ST_AP_ZERO: begin
                t_we = 1'b1; t_addr = taddr(r_cur, r_j);
                if (32'(r_j) == ALPHABET - 1) begin
                    n_st = ST_AP_WALK;
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            ST_AP_WALK: begin
                // read row(p)[c], link[p], len[p]
                t_addr = taddr(r_p[SW-1:0], r_c);
                k_addr = r_p[SW-1:0];
                l_addr = r_p[SW-1:0];
                n_st = ST_AP_WALKR;
            end
            ST_AP_WALKR: begin
                if (t_rd == '0) begin
                    t_we = 1'b1; t_addr = taddr(r_p[SW-1:0], r_c); t_wd = r_cur;
                    n_p = k_rd;
                    if (k_rd[SW]) begin
                        k_we = 1'b1; k_addr = r_cur; k_wd = '0;
                        n_st = ST_AP_LNK;
                    end else begin
                        n_st = ST_AP_WALK;
                    end
                end else begin
                    n_q = t_rd; n_plen = l_rd;
                    n_st = ST_AP_Q;
                end
            end
            ST_AP_Q: begin
                l_addr = r_q; k_addr = r_q;
                n_st = ST_AP_QR;
            end
            ST_AP_QR: begin
                if (l_rd == r_plen + LW'(1)) begin
                    k_we = 1'b1; k_addr = r_cur; k_wd = {1'b0, r_q};
                    n_st = ST_AP_LNK;
                end else begin
                    n_cl = r_cnt[SW-1:0];
                    n_cnt = r_cnt + CW'(1);
                    k_we = 1'b1; k_addr = r_cnt[SW-1:0]; k_wd = k_rd;
                    n_j = '0;
                    n_st = ST_AP_CPYR;
                end
            end
            ST_AP_CPYR: begin
                t_addr = taddr(r_q, r_j);
                if (r_j == '0) begin
                    l_we = 1'b1; l_addr = r_cl; l_wd = r_plen + LW'(1);
                end else if (r_j == AW'(1)) begin
                    k_we = 1'b1; k_addr = r_q; k_wd = {1'b0, r_cl};
                end
                n_st = ST_AP_CPYW;
            end
            ST_AP_CPYW: begin
                t_we = 1'b1; t_addr = taddr(r_cl, r_j); t_wd = t_rd;
                if (r_j == '0) begin
                    k_we = 1'b1; k_addr = r_cur; k_wd = {1'b0, r_cl};
                end
                if (32'(r_j) == ALPHABET - 1) begin
                    n_st = ST_AP_RED;
                end else begin
                    n_j = r_j + AW'(1);
                    n_st = ST_AP_CPYR;
                end
            end
            ST_AP_RED: begin
                t_addr = taddr(r_p[SW-1:0], r_c);
                k_addr = r_p[SW-1:0];
                n_st = ST_AP_REDR;
            end
            ST_AP_REDR: begin
                if (t_rd == r_q) begin
                    t_we = 1'b1; t_addr = taddr(r_p[SW-1:0], r_c); t_wd = r_cl;
                    n_p = k_rd;
                    n_st = k_rd[SW] ? ST_AP_LNK : ST_AP_RED;
                end else begin
                    n_st = ST_AP_LNK;
                end
            end
            ST_AP_LNK: begin
                n_last = r_cur; n_lastlen = r_lastlen + LW'(1);
                n_st = ST_OUT;
            end
            ST_QY_RD: begin
                t_addr = taddr(r_ms, r_c);
                n_st = ST_QY_RDR;
            end
            ST_QY_RDR: begin
                if (t_rd != '0) begin
                    n_ms = t_rd;
                    n_ml = r_ml + LW'(1);
                    l_addr = t_rd;
                    n_st = ST_QY_LENR;
                end else if (r_ms == '0) begin
                    n_ml = '0;
                    n_st = ST_OUT;
                end else begin
                    k_addr = r_ms;
                    n_st = ST_QY_LEN;
                end
            end
            ST_QY_LEN: begin
                // k_rd = link of current state; fetch its length
                n_ms = k_rd[SW-1:0];
                l_addr = k_rd[SW-1:0];
                n_p = '0;
                n_st = ST_QY_LENR;
                n_plen = '0;
                n_row = '1;
            end
            ST_QY_LENR: begin
                if (r_row == '1) begin
                    // after fallback: l = len[x], retry
                    n_ml = l_rd; n_row = '0;
                    n_st = ST_QY_RD;
                end else begin
                    if (r_ml > l_rd) n_ml = l_rd;
                    n_st = ST_OUT;
                end
            end
            default: begin  // ST_OUT
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1;
                    n_out.match_length = 15'(r_ml);
                    n_out.best_length = (r_ml > r_bl) ? 15'(r_ml) : 15'(r_bl);
                    n_bl = (r_ml > r_bl) ? r_ml : r_bl;
                    n_out.states_used = 16'(r_cnt);
                    n_out.status = r_stat;
                    n_row = '0;
                    n_st = ST_IDLE;
                end
            end
        endcase
    end

    property p_one_out;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_st == ST_OUT && n_st == ST_IDLE) |=> o_valid;
    endproperty
    a_one_out: assert property (p_one_out) else $error("result not posted");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> o_stall) else $error("accepting while busy");

    a_cnt_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != '0) else $error("state count zero");
endmodule
`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for suffix_automaton_common_substring
// Drives clear, append, query-begin and query items over a valid/stall link.
// A built-in automaton predicts every result. Phases vary sender idling and
// receiver stalls, and one phase holds the receiver off for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    import sacs_pkg::*;

    localparam int unsigned TEXT_CAP  = 16384;
    localparam int unsigned SYM_COUNT = 26;
    localparam int unsigned NO_LINK   = 32'hFFFF_FFFF;

    // predictor and expected-result store
    class lcs_board;
        int unsigned edge_to[int unsigned];
        int unsigned depth_of[];
        int unsigned link_of[];
        int unsigned tail, n_states, cur_node, cur_len, top_len;
        t_out_item   due[$];
        int          errors;

        function new();
            depth_of = new[2 * TEXT_CAP];
            link_of  = new[2 * TEXT_CAP];
            errors   = 0;
            wipe();
        endfunction

        function void wipe();
            edge_to.delete();
            depth_of[0] = 0;
            link_of[0]  = NO_LINK;
            n_states = 1;
            tail = 0;
            cur_node = 0;
            cur_len = 0;
            top_len = 0;
        endfunction

        function int unsigned go(int unsigned s, int unsigned c);
            int unsigned k;
            k = s * SYM_COUNT + c;
            return edge_to.exists(k) ? edge_to[k] : 0;
        endfunction

        function void extend(int unsigned c);
            int unsigned p, nw, q, cl;
            p  = tail;
            nw = n_states++;
            for (int i = 0; i < SYM_COUNT; i++) edge_to.delete(nw * SYM_COUNT + i);
            depth_of[nw] = depth_of[p] + 1;
            while (p != NO_LINK && go(p, c) == 0) begin
                edge_to[p * SYM_COUNT + c] = nw;
                p = link_of[p];
            end
            if (p == NO_LINK) begin
                link_of[nw] = 0;
            end else begin
                q = go(p, c);
                if (depth_of[q] == depth_of[p] + 1) begin
                    link_of[nw] = q;
                end else begin
                    cl = n_states++;
                    for (int i = 0; i < SYM_COUNT; i++) begin
                        if (go(q, i) != 0) edge_to[cl * SYM_COUNT + i] = go(q, i);
                        else edge_to.delete(cl * SYM_COUNT + i);
                    end
                    link_of[cl]  = link_of[q];
                    depth_of[cl] = depth_of[p] + 1;
                    link_of[q]   = cl;
                    link_of[nw]  = cl;
                    while (p != NO_LINK && go(p, c) == q) begin
                        edge_to[p * SYM_COUNT + c] = cl;
                        p = link_of[p];
                    end
                end
            end
            tail = nw;
        endfunction

        function void follow(int unsigned v);
            int unsigned x, l;
            x = cur_node;
            l = cur_len;
            if (v >= SYM_COUNT) begin
                x = 0;
                l = 0;
            end else begin
                while (x != 0 && go(x, v) == 0) begin
                    x = link_of[x];
                    l = depth_of[x];
                end
                if (go(x, v) != 0) begin
                    x = go(x, v);
                    l++;
                end
            end
            if (l > depth_of[x]) l = depth_of[x];
            cur_node = x;
            cur_len  = l;
            if (l > top_len) top_len = l;
        endfunction

        function void note_item(t_in_item it);
            t_out_item r;
            r.status = 1'b0;
            case (it.kind)
                KIND_CLEAR: wipe();
                KIND_APPEND: begin
                    if (depth_of[tail] >= TEXT_CAP) r.status = 1'b1;
                    else if (it.symbol < SYM_COUNT) extend(it.symbol);
                end
                KIND_QBEGIN: begin
                    cur_node = 0;
                    cur_len  = 0;
                    top_len  = 0;
                end
                default: follow(it.symbol);
            endcase
            r.match_length = cur_len[14:0];
            r.best_length  = top_len[14:0];
            r.states_used  = n_states[15:0];
            due.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item w;
            if (due.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            w = due.pop_front();
            if (got.match_length !== w.match_length) begin
                $display("%0t: match_length exp %0d got %0d", $time, w.match_length,
                         got.match_length);
                errors++;
            end
            if (got.best_length !== w.best_length) begin
                $display("%0t: best_length exp %0d got %0d", $time, w.best_length,
                         got.best_length);
                errors++;
            end
            if (got.states_used !== w.states_used) begin
                $display("%0t: states_used exp %0d got %0d", $time, w.states_used,
                         got.states_used);
                errors++;
            end
            if (got.status !== w.status) begin
                $display("%0t: status exp %0d got %0d", $time, w.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    suffix_automaton_common_substring dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    lcs_board    board = new();
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    bit          hold_req  = 0;
    int unsigned hold_left = 0;
    int unsigned items_sent = 0;
    logic [4:0]  text_syms[$];

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check_result(o_item);
        if (hold_req) begin
            hold_req  = 0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic offer_item(logic [1:0] kind, logic [4:0] sym);
        t_in_item it;
        it.kind   = kind;
        it.symbol = sym;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            i_item  <= t_in_item'(7'($urandom));
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        board.note_item(it);
        items_sent++;
        if (kind == KIND_CLEAR) text_syms.delete();
        if (kind == KIND_APPEND && sym < SYM_COUNT) text_syms.push_back(sym);
    endtask

    task automatic text_burst(int n, int unsigned alpha);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 3) offer_item(KIND_APPEND, 5'($urandom_range(31, 26)));
            else offer_item(KIND_APPEND, 5'($urandom_range(alpha - 1)));
        end
    endtask

    // mostly walks along the text so matches grow long, with random breaks
    task automatic query_burst(int n);
        int pos;
        pos = 0;
        offer_item(KIND_QBEGIN, 5'($urandom));
        for (int i = 0; i < n; i++) begin
            if (text_syms.size() > 0 && $urandom_range(99) < 75) begin
                if (pos >= text_syms.size() || $urandom_range(99) < 10)
                    pos = $urandom_range(text_syms.size() - 1);
                offer_item(KIND_QUERY, text_syms[pos]);
                pos++;
            end else if ($urandom_range(99) < 10) begin
                offer_item(KIND_QUERY, 5'($urandom_range(31, 26)));
            end else begin
                offer_item(KIND_QUERY, 5'($urandom_range(25)));
            end
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.due.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned pick;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item  <= '0;
        i_stall <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty automaton, extremes, clones, odd symbols
        offer_item(KIND_QUERY, 5'd0);
        offer_item(KIND_APPEND, 5'd0);
        offer_item(KIND_APPEND, 5'd25);
        offer_item(KIND_APPEND, 5'd31);
        offer_item(KIND_APPEND, 5'd26);
        offer_item(KIND_APPEND, 5'd0);
        offer_item(KIND_APPEND, 5'd25);
        offer_item(KIND_APPEND, 5'd25);
        offer_item(KIND_APPEND, 5'd0);
        offer_item(KIND_QUERY, 5'd25);
        offer_item(KIND_QBEGIN, 5'd31);
        offer_item(KIND_QUERY, 5'd0);
        offer_item(KIND_QUERY, 5'd25);
        offer_item(KIND_QUERY, 5'd25);
        offer_item(KIND_QUERY, 5'd0);
        offer_item(KIND_QUERY, 5'd31);
        offer_item(KIND_QUERY, 5'd25);
        offer_item(KIND_APPEND, 5'd1);
        offer_item(KIND_QUERY, 5'd1);
        offer_item(KIND_QUERY, 5'd7);
        offer_item(KIND_CLEAR, 5'd31);
        offer_item(KIND_QUERY, 5'd0);
        offer_item(KIND_QBEGIN, 5'd0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            if (ph == 2) hold_req = 1;
            while (items_sent < 23 + (ph + 1) * 155) begin
                pick = $urandom_range(99);
                if (pick < 5) offer_item(KIND_CLEAR, 5'($urandom));
                else if (pick < 50)
                    text_burst($urandom_range(30, 1),
                               ($urandom_range(2) == 0) ? 26 : $urandom_range(3, 2));
                else query_burst($urandom_range(25, 1));
            end
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (board.errors == 0 && board.due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
